>>> rtl/icf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Fenwick-tree inversion counter.
// No dependencies; imported by every module of the block.
package icf_pkg;

   localparam int IN_W  = 20;   // value_in width
   localparam int CNT_W = 30;   // count / total width

   localparam logic [CNT_W:0]   MODULUS = 31'd1000000007;
   localparam logic [CNT_W-1:0] CNT_ONE = 30'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUERY,
      ST_UPDATE,
      ST_RESULT
   } icf_state_type;

   // start of one request toward the walker
   typedef struct packed {
      logic start;
      logic bad;
   } icf_cmd_type;

   // walker status back to the top
   typedef struct packed {
      logic             ready;
      logic             done;
      logic             bad;
      logic [CNT_W-1:0] total;
   } icf_stat_type;

   // a + b mod 1e9+7, both operands already below the modulus
   function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= MODULUS) begin
         sum = sum - MODULUS;
      end
      return sum[CNT_W-1:0];
   endfunction

endpackage

>>> rtl/inversion_counter_fenwick.sv
`timescale 1ns / 1ps
// Inversion counter over a Fenwick (binary indexed) frequency tree, top level.
// Depends on icf_pkg, icf_tree_ram and icf_walker.
//
// Feed the sequence from its last element to its first. For each value v the
// block adds the count of earlier values below v to a running total mod
// 1000000007, records v in the tree, and returns the total as one response.
// A value of zero or of 2^VALUE_BITS and above is flagged in rsp_tuser and
// leaves tree and total untouched. After reset the block sweeps the tree
// memory to zero, one entry per cycle, with req_tready low. The query walk
// reads one entry per set bit of v-1 and the update walk one per update
// step; the two counts always add up to VALUE_BITS. The next request can be
// taken the cycle after the walker hands its result over. A flagged request
// goes from idle straight to the result state, skipping both walks. The
// walks are paced by the single read port of the tree memory, which the
// query walk and the update read-modify-write walk use one entry per cycle.
// An output register holds the last response, so the next request is taken
// while it waits for rsp_tready.
module inversion_counter_fenwick
   import icf_pkg::*;
#(
   parameter int VALUE_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // [19:0] value_in, [23:20] zero
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [29:0] inversions, [31:30] zero
   output logic        rsp_tuser     // [0] bad_value
);

   // wide enough to hold any input and the tree size itself
   localparam int EXT_W = ((VALUE_BITS > IN_W) ? VALUE_BITS : IN_W) + 1;

   logic [EXT_W-1:0]      val_ext;
   logic [VALUE_BITS-1:0] pos;
   logic                  accept;
   logic                  slot_free;

   icf_cmd_type  cmd;
   icf_stat_type stat;

   logic                  ram_we;
   logic [VALUE_BITS-1:0] ram_waddr;
   logic [CNT_W-1:0]      ram_wdata;
   logic                  ram_re;
   logic [VALUE_BITS-1:0] ram_raddr;
   logic [CNT_W-1:0]      ram_rdata;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_total_ff, rsp_total_in;
   logic             rsp_bad_ff, rsp_bad_in;

   assign val_ext = EXT_W'(req_tdata[IN_W-1:0]);
   assign pos     = val_ext[VALUE_BITS-1:0];

   assign req_tready = stat.ready;
   assign accept     = req_tvalid & req_tready;

   // zero, or any bit at or above the tree size, is rejected
   assign cmd.start = accept;
   assign cmd.bad   = (val_ext == '0) || ((val_ext >> VALUE_BITS) != '0);

   // walker may hand over a result when the output register is free or draining
   assign slot_free = ~rsp_valid_ff | rsp_tready;

   icf_walker #(
      .VALUE_BITS(VALUE_BITS)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_pos   (pos),
      .slot_free (slot_free),
      .stat      (stat),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   icf_tree_ram #(
      .VALUE_BITS(VALUE_BITS)
   ) u_tree_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_total_in = rsp_total_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_total_in = stat.total;
         rsp_bad_in   = stat.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_total_ff <= rsp_total_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_total_ff};
   assign rsp_tuser  = rsp_bad_ff;

endmodule

>>> rtl/icf_tree_ram.sv
`timescale 1ns / 1ps
// Frequency tree storage: one write port, one read port, registered read data.
// Depends on icf_pkg.
module icf_tree_ram
   import icf_pkg::*;
#(
   parameter int VALUE_BITS = 20
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [VALUE_BITS-1:0] waddr,
   input  logic [CNT_W-1:0]      wdata,
   input  logic                  re,
   input  logic [VALUE_BITS-1:0] raddr,
   output logic [CNT_W-1:0]      rdata
);

   localparam int DEPTH = 1 << VALUE_BITS;

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/icf_walker.sv
`timescale 1ns / 1ps
// Sequencer for the tree: clearing pass, prefix query walk, update walk
// and running total. Depends on icf_pkg; drives icf_tree_ram ports.
module icf_walker
   import icf_pkg::*;
#(
   parameter int VALUE_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  icf_cmd_type           cmd,
   input  logic [VALUE_BITS-1:0] cmd_pos,
   input  logic                  slot_free,
   output icf_stat_type          stat,
   output logic                  ram_we,
   output logic [VALUE_BITS-1:0] ram_waddr,
   output logic [CNT_W-1:0]      ram_wdata,
   output logic                  ram_re,
   output logic [VALUE_BITS-1:0] ram_raddr,
   input  logic [CNT_W-1:0]      ram_rdata
);

   icf_state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] clr_ptr_ff, clr_ptr_in;
   logic [VALUE_BITS-1:0] qpos_ff, qpos_in;
   logic [VALUE_BITS:0]   upos_ff, upos_in;    // top bit set = walked off the tree
   logic [VALUE_BITS-1:0] waddr_ff, waddr_in;
   logic                  pend_ff, pend_in;    // read issued last cycle
   logic [CNT_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic                  bad_ff, bad_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = cmd.bad ? ST_RESULT : ST_QUERY;
            end
         end
         ST_QUERY: begin
            if (qpos_ff == '0 && !pend_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upos_ff[VALUE_BITS] && !pend_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_ptr_in = clr_ptr_ff;
      qpos_in    = qpos_ff;
      upos_in    = upos_ff;
      waddr_in   = waddr_ff;
      pend_in    = pend_ff;
      acc_in     = acc_ff;
      total_in   = total_ff;
      bad_in     = bad_ff;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = '0;
      ram_re     = 1'b0;
      ram_raddr  = '0;
      stat.ready = 1'b0;
      stat.done  = 1'b0;
      stat.bad   = bad_ff;
      stat.total = total_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            stat.ready = 1'b1;
            if (cmd.start) begin
               bad_in  = cmd.bad;
               qpos_in = cmd_pos - 1'b1;
               upos_in = {1'b0, cmd_pos};
               acc_in  = '0;
               pend_in = 1'b0;
            end
         end
         ST_QUERY: begin
            // reads are independent: one issued per cycle, summed once the registered read data arrives
            if (pend_ff) begin
               acc_in = add_mod(acc_ff, ram_rdata);
            end
            if (qpos_ff != '0) begin
               ram_re    = 1'b1;
               ram_raddr = qpos_ff;
               qpos_in   = qpos_ff & (qpos_ff - 1'b1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  total_in = add_mod(total_ff, acc_ff);
               end
            end
         end
         ST_UPDATE: begin
            // addresses strictly increase, so read of the next entry overlaps
            // write-back of the previous one without a hazard
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = waddr_ff;
               ram_wdata = add_mod(ram_rdata, CNT_ONE);
            end
            if (!upos_ff[VALUE_BITS]) begin
               ram_re    = 1'b1;
               ram_raddr = upos_ff[VALUE_BITS-1:0];
               waddr_in  = upos_ff[VALUE_BITS-1:0];
               upos_in   = upos_ff + (upos_ff & (~upos_ff + 1'b1));
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_RESULT: begin
            stat.done = slot_free;
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ptr_ff <= '0;
         pend_ff    <= 1'b0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
         pend_ff    <= pend_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      qpos_ff  <= qpos_in;
      upos_ff  <= upos_in;
      waddr_ff <= waddr_in;
      acc_ff   <= acc_in;
      bad_ff   <= bad_in;
   end

endmodule

>>> bench/inversion_counter_fenwick_checker.sv
`timescale 1ns / 1ps
// Stream checker for the Fenwick-tree inversion counter: watches both channels,
// predicts every response from its own frequency tree and compares. Uses icf_pkg.
module inversion_counter_fenwick_checker
   import icf_pkg::*;
#(
   parameter int VALUE_BITS = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [23:0]      req_tdata,    // [19:0] value_in
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [31:0]      rsp_tdata,    // [29:0] inversions
   input  logic             rsp_tuser,    // [0] bad_value
   output int               fail_count,
   output int               pending,
   output int               req_count,
   output int               flagged_count,
   output logic [CNT_W-1:0] total_seen
);

   localparam int unsigned TREE_DEPTH = 1 << VALUE_BITS;
   localparam int MAX_PRINTS = 30;

   typedef struct packed {
      logic [CNT_W-1:0] inversions;
      logic             bad_value;
   } tally_type;

   // two-state storage starts at zero; reset is applied once, before any request
   bit [CNT_W-1:0] freq [TREE_DEPTH];
   bit [CNT_W-1:0] run_total;
   tally_type      tally_due [$];
   int             resp_count;

   function automatic logic [CNT_W-1:0] mod_sum(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = a + b;
      if (s >= MODULUS) begin
         return s[CNT_W-1:0] - MODULUS[CNT_W-1:0];
      end
      return s[CNT_W-1:0];
   endfunction

   // how many earlier values lie strictly below v
   function automatic logic [CNT_W-1:0] count_below(input int unsigned v);
      int unsigned      pos;
      logic [CNT_W-1:0] acc;
      pos = v - 1;
      acc = '0;
      while (pos != 0) begin
         acc = mod_sum(acc, freq[pos]);
         pos = pos - (pos & (~pos + 1));
      end
      return acc;
   endfunction

   function automatic void add_occurrence(input int unsigned v);
      int unsigned pos;
      pos = v;
      while (pos != 0 && pos < TREE_DEPTH) begin
         freq[pos] = mod_sum(freq[pos], CNT_ONE);
         pos = pos + (pos & (~pos + 1));
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      fail_count++;
      if (fail_count <= MAX_PRINTS) begin
         $display("[%0t] response %0d, %s: got %0d, expected %0d",
                  $time, resp_count, what, got, want);
      end
   endtask

   always @(posedge clock) begin : watch
      tally_type   got;
      tally_type   want;
      int unsigned v;
      if (reset) begin
         run_total = '0;
         tally_due.delete();
      end else begin
         // responses first: a response never belongs to a request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.inversions = rsp_tdata[CNT_W-1:0];
            got.bad_value  = rsp_tuser;
            if (tally_due.size() == 0) begin
               report_mismatch("no request outstanding", got.inversions, 0);
            end else begin
               want = tally_due.pop_front();
               if (got.inversions !== want.inversions) begin
                  report_mismatch("inversions", got.inversions, want.inversions);
               end
               if (got.bad_value !== want.bad_value) begin
                  report_mismatch("bad_value", got.bad_value, want.bad_value);
               end
            end
            resp_count++;
         end
         if (req_tvalid && req_tready) begin
            v = req_tdata[IN_W-1:0];
            want.bad_value = (v == 0 || v >= TREE_DEPTH);
            if (want.bad_value) begin
               flagged_count++;
            end else begin
               run_total = mod_sum(run_total, count_below(v));
               add_occurrence(v);
            end
            want.inversions = run_total;
            tally_due.push_back(want);
            req_count++;
         end
      end
      pending    = tally_due.size();
      total_seen = run_total;
   end

endmodule

>>> bench/inversion_counter_fenwick_tb.sv
`timescale 1ns / 1ps
// Top of the inversion counter testbench: clock, reset, request and response
// drivers, verdict. Uses icf_pkg, the block and inversion_counter_fenwick_checker.
module inversion_counter_fenwick_tb;
   import icf_pkg::*;

   localparam int VALUE_BITS      = 20;
   localparam int HALF_PERIOD     = 2;
   localparam int RESET_CYCLES    = 10;
   localparam int RANDOM_ITEMS    = 1080;
   localparam int QUIET_FROM      = 930;    // from here on neither side idles
   localparam int HOLD_AT         = 300;    // request index where the long hold-off starts
   localparam int RSP_HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES     = 2 * VALUE_BITS + 24;
   localparam int DRAIN_LIMIT     = 20000;
   // clearing sweep of the whole tree plus the stalled request stream, about 4x over
   localparam int RUN_LIMIT_NS    = 20_000_000;
   localparam logic [IN_W-1:0] MAX_VALUE = IN_W'((1 << VALUE_BITS) - 1);

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [23:0]      req_tdata;    // [19:0] value_in, [23:20] zero
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [31:0]      rsp_tdata;    // [29:0] inversions, [31:30] zero
   logic             rsp_tuser;    // [0] bad_value

   int               fail_count;
   int               pending;
   int               req_count;
   int               flagged_count;
   logic [CNT_W-1:0] total_seen;

   // handshake knobs: set by the stimulus, read by the response driver
   bit               rsp_stalls_on = 1'b0;
   bit               hold_rsp      = 1'b0;

   inversion_counter_fenwick #(
      .VALUE_BITS (VALUE_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   inversion_counter_fenwick_checker #(
      .VALUE_BITS (VALUE_BITS)
   ) check_u (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending       (pending),
      .req_count     (req_count),
      .flagged_count (flagged_count),
      .total_seen    (total_seen)
   );

   always begin
      clock = 1'b0;
      #(HALF_PERIOD);
      clock = 1'b1;
      #(HALF_PERIOD);
   end

   // Offer one value and hold it until the block takes the request.
   // tvalid stays high on return so back-to-back requests never drop it.
   task automatic push_value(input logic [IN_W-1:0] v);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(24 - IN_W){1'b0}}, v};
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   // Value mix: a narrow range for 42 in 100 draws so inversions and repeats pile up,
   // plus values near the top, long query/update walks, the full range and the odd zero.
   function automatic logic [IN_W-1:0] draw_value();
      int unsigned     sel;
      int unsigned     k;
      logic [IN_W-1:0] v;
      sel = $urandom_range(0, 99);
      k   = $urandom_range(0, VALUE_BITS - 1);
      if (sel < 3) begin
         v = '0;
      end else if (sel < 45) begin
         v = IN_W'($urandom_range(1, 48));
      end else if (sel < 60) begin
         v = MAX_VALUE - IN_W'($urandom_range(0, 31));
      end else if (sel < 65) begin
         v = IN_W'(1 << k);                       // power of two: the update walk visits every higher power of two
      end else if (sel < 70) begin
         v = IN_W'((1 << (k + 1)) - 1);           // many set bits in v-1: long query walk
      end else begin
         v = IN_W'($urandom_range(1, MAX_VALUE));
      end
      return v;
   endfunction

   // Response side: random ready/stall bursts, one long hold-off on request.
   initial begin : rsp_driver
      bit hold_done;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         if (hold_rsp && !hold_done) begin
            // long hold-off: output register fills, block stops taking requests
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [IN_W-1:0] corner_values [0:19];
      bit              idle_on;
      int              drain;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      idle_on    = 1'b0;
      // zero on an empty tree, repeats (no inversion for equal values),
      // both ends of the range, powers of two, all-ones and alternating patterns
      corner_values = '{20'h00000, 20'h00001, 20'h00001, 20'hFFFFF, 20'h80000,
                        20'h7FFFF, 20'h00002, 20'h00003, 20'h00000, 20'h55555,
                        20'hAAAAA, 20'h40001, 20'h0FFFF, 20'h10000, 20'hFFFFE,
                        20'h00004, 20'hFFFFF, 20'h00000, 20'h00001, 20'h00800};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // the block sweeps its tree first; the first request just waits for tready
      foreach (corner_values[i]) begin
         push_value(corner_values[i]);
      end

      rsp_stalls_on = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // idling switches on and off in windows so clean stretches occur too
         if (i % 64 == 0) begin
            idle_on = (i < QUIET_FROM) && ($urandom_range(0, 2) != 0);
         end
         if (i == QUIET_FROM) begin
            idle_on       = 1'b0;
            rsp_stalls_on = 1'b0;
         end
         if (i == HOLD_AT) begin
            hold_rsp = 1'b1;
         end
         push_value(draw_value());
         if (idle_on && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // sample at the falling edge so the checker's updates are settled
      drain = 0;
      do begin
         @(negedge clock);
         drain++;
      end while (pending != 0 && drain < DRAIN_LIMIT);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Run: %0d requests (%0d zero values flagged), directed corners then random",
               req_count, flagged_count);
      $display("values under bursty idling and a %0d-cycle response hold-off; final count %0d",
               RSP_HOLD_CYCLES, total_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         if (pending != 0) begin
            $display("%0d responses never arrived", pending);
         end
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d responses outstanding", pending);
      $display("Verification failed");
      $finish;
   end

endmodule

>>> files.f
rtl/icf_pkg.sv
rtl/icf_tree_ram.sv
rtl/icf_walker.sv
rtl/inversion_counter_fenwick.sv
bench/inversion_counter_fenwick_checker.sv
bench/inversion_counter_fenwick_tb.sv
